// ===== design/wpb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpb_pkg
// shared types and constants of the weighted pixel blender
// ----------------------------------------------------------------------------
package wpb_pkg;

   localparam int CHAN_BITS      = 8;
   localparam int DIM_BITS       = 15;
   localparam int QUOTIENT_BITS  = 8;
   localparam int BIT_CNT_BITS   = $clog2(QUOTIENT_BITS);
   localparam int NUM_CHANNELS   = 3;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef logic [CHAN_BITS-1:0] chan_type;
   typedef logic [DIM_BITS-1:0]  dim_type;

   localparam chan_type ALPHA_THRESHOLD = 8'd127;
   localparam chan_type FULL_ALPHA      = 8'd255;

   // channel order inside the datapath arrays
   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;

endpackage
`default_nettype wire

// ===== design/wpb_intf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpb_intf
// valid/ready channels of the weighted pixel blender
// ----------------------------------------------------------------------------
interface wpb_req_if
   import wpb_pkg::*;
#(
   parameter int WEIGHT_BITS = 24,
   parameter int COORD_BITS  = 16
) ();
   logic                          valid;
   logic                          ready;
   chan_type                      blue;
   chan_type                      green;
   chan_type                      red;
   chan_type                      alpha;
   logic [WEIGHT_BITS-1:0]        weight;
   logic signed [COORD_BITS-1:0]  local_x;
   logic signed [COORD_BITS-1:0]  local_y;
   dim_type                       image_width;
   dim_type                       image_height;
   logic                          last_source;

   modport source (
      output valid, blue, green, red, alpha, weight, local_x, local_y,
             image_width, image_height, last_source,
      input  ready
   );
   modport sink (
      input  valid, blue, green, red, alpha, weight, local_x, local_y,
             image_width, image_height, last_source,
      output ready
   );
endinterface

interface wpb_rsp_if
   import wpb_pkg::*;
();
   logic     valid;
   logic     ready;
   chan_type out_blue;
   chan_type out_green;
   chan_type out_red;
   chan_type out_alpha;

   modport source (
      output valid, out_blue, out_green, out_red, out_alpha,
      input  ready
   );
   modport sink (
      input  valid, out_blue, out_green, out_red, out_alpha,
      output ready
   );
endinterface

interface wpb_csr_if ();
   logic valid;
   logic ready;
   logic alpha_mode;

   modport source (output valid, alpha_mode, input ready);
   modport sink (input valid, alpha_mode, output ready);
endinterface
`default_nettype wire

// ===== design/wpb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpb_front
// accepts contributions, checks bounds and mode, forms weighted colors
// ----------------------------------------------------------------------------
module wpb_front
   import wpb_pkg::*;
#(
   parameter int WEIGHT_BITS = 24,
   parameter int COORD_BITS  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   wpb_req_if.sink                          req_chan,
   wpb_csr_if.sink                          csr_chan,
   output logic                             ctb_valid,
   input  logic                             ctb_ready,
   output logic [WEIGHT_BITS+CHAN_BITS-1:0] ctb_color [NUM_CHANNELS],
   output logic [WEIGHT_BITS-1:0]           ctb_weight,
   output logic                             ctb_last
);

   localparam int PW   = WEIGHT_BITS + CHAN_BITS;
   localparam int CMPW = (COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1;

   logic                   alpha_mode_ff, alpha_mode_in;
   logic                   valid_ff, valid_in;
   logic [PW-1:0]          color_ff [NUM_CHANNELS];
   logic [PW-1:0]          color_in [NUM_CHANNELS];
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic                   last_ff, last_in;

   logic                   take;
   logic signed [CMPW-1:0] x_ext, y_ext, wd_ext, ht_ext;
   logic                   in_bounds;
   logic                   counted;
   logic [WEIGHT_BITS-1:0] w_eff;
   chan_type               chan_val [NUM_CHANNELS];

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !valid_ff || ctb_ready;
   assign take           = req_chan.valid && req_chan.ready;

   assign x_ext     = CMPW'(req_chan.local_x);
   assign y_ext     = CMPW'(req_chan.local_y);
   assign wd_ext    = $signed(CMPW'(req_chan.image_width));
   assign ht_ext    = $signed(CMPW'(req_chan.image_height));
   assign in_bounds = !x_ext[CMPW-1] && (x_ext < wd_ext) &&
                      !y_ext[CMPW-1] && (y_ext < ht_ext);

   assign counted = in_bounds && (!alpha_mode_ff || (req_chan.alpha > ALPHA_THRESHOLD));
   assign w_eff   = !counted ? '0 :
                    alpha_mode_ff ? WEIGHT_BITS'(1) : req_chan.weight;

   assign chan_val[CH_BLUE]  = req_chan.blue;
   assign chan_val[CH_GREEN] = req_chan.green;
   assign chan_val[CH_RED]   = req_chan.red;

   always_comb begin
      alpha_mode_in = alpha_mode_ff;
      valid_in      = valid_ff;
      weight_in     = weight_ff;
      last_in       = last_ff;
      color_in      = color_ff;
      if (csr_chan.valid) begin
         alpha_mode_in = csr_chan.alpha_mode;
      end
      if (take) begin
         valid_in  = 1'b1;
         weight_in = w_eff;
         last_in   = req_chan.last_source;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            color_in[c] = PW'(w_eff) * PW'(chan_val[c]);
         end
      end else if (ctb_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_mode_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         alpha_mode_ff <= alpha_mode_in;
         valid_ff      <= valid_in;
      end
      weight_ff <= weight_in;
      last_ff   <= last_in;
      color_ff  <= color_in;
   end

   assign ctb_valid  = valid_ff;
   assign ctb_color  = color_ff;
   assign ctb_weight = weight_ff;
   assign ctb_last   = last_ff;

endmodule
`default_nettype wire

// ===== design/wpb_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpb_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module wpb_queue
   import wpb_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0]          slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      push, pop;

   assign push_ready = count_ff != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_PTR_BITS+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== design/wpb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpb_back
// saturating accumulation and per-pixel rounded division
// ----------------------------------------------------------------------------
module wpb_back
   import wpb_pkg::*;
#(
   parameter int WEIGHT_BITS = 24,
   parameter int MAX_SOURCES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             ctb_valid,
   output logic                             ctb_ready,
   input  logic [WEIGHT_BITS+CHAN_BITS-1:0] ctb_color [NUM_CHANNELS],
   input  logic [WEIGHT_BITS-1:0]           ctb_weight,
   input  logic                             ctb_last,
   wpb_rsp_if.source                        rsp_chan
);

   localparam int SB = $clog2(MAX_SOURCES);
   localparam int CW = WEIGHT_BITS + CHAN_BITS + SB;
   localparam int TW = WEIGHT_BITS + SB;
   localparam int NW = CW + 2;

   localparam logic [1:0] ST_ACCUM = 2'd0;
   localparam logic [1:0] ST_PREP  = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [CW-1:0]           total_ff [NUM_CHANNELS];
   logic [CW-1:0]           total_in [NUM_CHANNELS];
   logic [TW-1:0]           wtotal_ff, wtotal_in;
   logic [NW-1:0]           rem_ff [NUM_CHANNELS];
   logic [NW-1:0]           rem_in [NUM_CHANNELS];
   logic [NW-1:0]           dsh_ff, dsh_in;
   chan_type                q_ff [NUM_CHANNELS];
   chan_type                q_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] clamp_ff, clamp_in;
   logic                    zero_ff, zero_in;
   logic [BIT_CNT_BITS-1:0] bit_ff, bit_in;

   logic [CW:0]             color_sum [NUM_CHANNELS];
   logic [CW-1:0]           color_sat [NUM_CHANNELS];
   logic [TW:0]             w_sum;
   logic [TW-1:0]           w_sat;
   logic [NW-1:0]           numer [NUM_CHANNELS];
   logic [NW-1:0]           denom;
   logic [NW-1:0]           limit;
   logic [NW-1:0]           trial [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] take;
   chan_type                result [NUM_CHANNELS];

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         color_sum[c] = {1'b0, total_ff[c]} + (CW+1)'(ctb_color[c]);
         color_sat[c] = color_sum[c][CW] ? '1 : color_sum[c][CW-1:0];
         numer[c]     = NW'({total_ff[c], 1'b0}) + NW'(wtotal_ff);
         trial[c]     = rem_ff[c] - dsh_ff;
         take[c]      = rem_ff[c] >= dsh_ff;
         result[c]    = zero_ff ? '0 : (clamp_ff[c] ? FULL_ALPHA : q_ff[c]);
      end
      w_sum = {1'b0, wtotal_ff} + (TW+1)'(ctb_weight);
      w_sat = w_sum[TW] ? '1 : w_sum[TW-1:0];
      denom = NW'({wtotal_ff, 1'b0});
      limit = denom << QUOTIENT_BITS;
   end

   always_comb begin
      state_in  = state_ff;
      total_in  = total_ff;
      wtotal_in = wtotal_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      q_in      = q_ff;
      clamp_in  = clamp_ff;
      zero_in   = zero_ff;
      bit_in    = bit_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (ctb_valid) begin
               total_in  = color_sat;
               wtotal_in = w_sat;
               if (ctb_last) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               rem_in[c]   = numer[c];
               clamp_in[c] = numer[c] >= limit;
               q_in[c]     = '0;
               total_in[c] = '0;
            end
            zero_in   = wtotal_ff == '0;
            dsh_in    = denom << (QUOTIENT_BITS - 1);
            bit_in    = BIT_CNT_BITS'(QUOTIENT_BITS - 1);
            wtotal_in = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               if (take[c]) begin
                  rem_in[c] = trial[c];
               end
               q_in[c] = {q_ff[c][CHAN_BITS-2:0], take[c]};
            end
            dsh_in = dsh_ff >> 1;
            bit_in = bit_ff - BIT_CNT_BITS'(1);
            if (bit_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_ACCUM;
         total_ff  <= '{default: '0};
         wtotal_ff <= '0;
      end else begin
         state_ff  <= state_in;
         total_ff  <= total_in;
         wtotal_ff <= wtotal_in;
      end
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      q_ff     <= q_in;
      clamp_ff <= clamp_in;
      zero_ff  <= zero_in;
      bit_ff   <= bit_in;
   end

   assign ctb_ready          = state_ff == ST_ACCUM;
   assign rsp_chan.valid     = state_ff == ST_OUT;
   assign rsp_chan.out_blue  = result[CH_BLUE];
   assign rsp_chan.out_green = result[CH_GREEN];
   assign rsp_chan.out_red   = result[CH_RED];
   assign rsp_chan.out_alpha = zero_ff ? '0 : FULL_ALPHA;

endmodule
`default_nettype wire

// ===== design/weighted_pixel_blender_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_pixel_blender_unit
// feather-weighted average of one output pixel over its source contributions
// ----------------------------------------------------------------------------
// req_chan takes one contribution per transaction (BGRA, weight, local
// coordinates, image size, last_source). rsp_chan gives one blended BGRA
// pixel per run, on the transaction marked last_source. csr_chan writes
// alpha_mode and is always ready; write it only while the block is idle.
// The front stage checks bounds and mode and registers weight times color,
// then passes the transaction through a four-entry queue to the back stage.
// Throughput: one contribution per cycle while the back stage accumulates.
// A last contribution holds the back stage through accumulate, operand
// setup, 8 restoring division steps and result, shared by all three
// channels; the queue keeps accepting meanwhile until it fills.
// The result stays on rsp_chan until taken; while the receiver stalls the
// back stage waits and the front fills the queue, then drops req ready.
// Reset clears the totals, the queue and alpha_mode (mask mode).
// ----------------------------------------------------------------------------
module weighted_pixel_blender_unit
   import wpb_pkg::*;
#(
   parameter int MAX_SOURCES = 8,
   parameter int WEIGHT_BITS = 24,
   parameter int COORD_BITS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   wpb_req_if.sink   req_chan,
   wpb_rsp_if.source rsp_chan,
   wpb_csr_if.sink   csr_chan
);

   localparam int PW = WEIGHT_BITS + CHAN_BITS;
   localparam int QW = 1 + WEIGHT_BITS + NUM_CHANNELS * PW;

   logic                   f_valid, f_ready;
   logic [PW-1:0]          f_color [NUM_CHANNELS];
   logic [WEIGHT_BITS-1:0] f_weight;
   logic                   f_last;
   logic [QW-1:0]          f_data;

   logic                   b_valid, b_ready;
   logic [QW-1:0]          b_data;
   logic [PW-1:0]          b_color [NUM_CHANNELS];
   logic [WEIGHT_BITS-1:0] b_weight;
   logic                   b_last;

   wpb_front #(
      .WEIGHT_BITS (WEIGHT_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .ctb_valid  (f_valid),
      .ctb_ready  (f_ready),
      .ctb_color  (f_color),
      .ctb_weight (f_weight),
      .ctb_last   (f_last)
   );

   assign f_data = {f_last, f_weight, f_color[CH_RED], f_color[CH_GREEN], f_color[CH_BLUE]};

   wpb_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_data)
   );

   assign b_color[CH_BLUE]  = b_data[PW-1:0];
   assign b_color[CH_GREEN] = b_data[2*PW-1:PW];
   assign b_color[CH_RED]   = b_data[3*PW-1:2*PW];
   assign b_weight          = b_data[3*PW+WEIGHT_BITS-1:3*PW];
   assign b_last            = b_data[QW-1];

   wpb_back #(
      .WEIGHT_BITS (WEIGHT_BITS),
      .MAX_SOURCES (MAX_SOURCES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .ctb_valid  (b_valid),
      .ctb_ready  (b_ready),
      .ctb_color  (b_color),
      .ctb_weight (b_weight),
      .ctb_last   (b_last),
      .rsp_chan   (rsp_chan)
   );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// The testbench streams pixel contributions into the weighted pixel blender
// in both mask and alpha mode. It first sends directed runs, then random runs
// of one to twelve sources. The sender pauses between bursts and the receiver
// stalls at random. A scoreboard keeps its own color and weight totals with
// saturation and rounds each blend half up. It compares every blended pixel
// field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module tb_top;
   import wpb_pkg::*;

   localparam bit MODE_MASK  = 1'b0;
   localparam bit MODE_ALPHA = 1'b1;

   localparam int RX_OPEN   = 0;
   localparam int RX_COIN   = 1;
   localparam int RX_BLOCK  = 2;
   localparam int RX_TOGGLE = 3;

   localparam int ITEMS_PER_PHASE = 288;
   localparam int DRAIN_CYCLES    = 24;
   localparam int CYCLE_LIMIT     = 600000;

   localparam logic [34:0] COLOR_MAX  = {35{1'b1}};
   localparam logic [26:0] WEIGHT_MAX = {27{1'b1}};

   typedef struct packed {
      chan_type            blue;
      chan_type            green;
      chan_type            red;
      chan_type            alpha;
      logic [23:0]         weight;
      logic signed [15:0]  local_x;
      logic signed [15:0]  local_y;
      dim_type             image_width;
      dim_type             image_height;
      logic                last_source;
   } contrib_type;

   typedef struct packed {
      chan_type blue;
      chan_type green;
      chan_type red;
      chan_type alpha;
   } pixel_type;

   class blend_scoreboard;
      bit          alpha_mode;
      logic [34:0] blue_sum;
      logic [34:0] green_sum;
      logic [34:0] red_sum;
      logic [26:0] wt_total;
      pixel_type   blended_q[$];
      int          errors;

      function new();
         alpha_mode = MODE_MASK;
         clear_sums();
         errors = 0;
      endfunction

      function void clear_sums();
         blue_sum  = '0;
         green_sum = '0;
         red_sum   = '0;
         wt_total  = '0;
      endfunction

      function logic [34:0] add_color(logic [34:0] acc, logic [31:0] amount);
         logic [35:0] s;
         s = {1'b0, acc} + {4'b0, amount};
         return (s > {1'b0, COLOR_MAX}) ? COLOR_MAX : s[34:0];
      endfunction

      function logic [26:0] add_weight(logic [26:0] acc, logic [23:0] amount);
         logic [27:0] s;
         s = {1'b0, acc} + {4'b0, amount};
         return (s > {1'b0, WEIGHT_MAX}) ? WEIGHT_MAX : s[26:0];
      endfunction

      function chan_type blend(logic [34:0] total, logic [26:0] wsum);
         longint unsigned t;
         longint unsigned w;
         longint unsigned q;
         t = total;
         w = wsum;
         q = (2 * t + w) / (2 * w);
         return (q > 255) ? 8'd255 : q[7:0];
      endfunction

      function int outstanding();
         return blended_q.size();
      endfunction

      function void note_input(contrib_type c);
         int        x;
         int        y;
         int        wd;
         int        ht;
         bit        in_bounds;
         pixel_type p;
         x = int'($signed(c.local_x));
         y = int'($signed(c.local_y));
         wd = int'(c.image_width);
         ht = int'(c.image_height);
         in_bounds = (x >= 0) && (x < wd) && (y >= 0) && (y < ht);
         if (in_bounds) begin
            if (alpha_mode == MODE_ALPHA) begin
               if (c.alpha > ALPHA_THRESHOLD) begin
                  blue_sum  = add_color(blue_sum, {24'b0, c.blue});
                  green_sum = add_color(green_sum, {24'b0, c.green});
                  red_sum   = add_color(red_sum, {24'b0, c.red});
                  wt_total  = add_weight(wt_total, 24'd1);
               end
            end else begin
               blue_sum  = add_color(blue_sum, 32'(c.weight) * 32'(c.blue));
               green_sum = add_color(green_sum, 32'(c.weight) * 32'(c.green));
               red_sum   = add_color(red_sum, 32'(c.weight) * 32'(c.red));
               wt_total  = add_weight(wt_total, c.weight);
            end
         end
         if (c.last_source) begin
            if (wt_total != 0) begin
               p.blue  = blend(blue_sum, wt_total);
               p.green = blend(green_sum, wt_total);
               p.red   = blend(red_sum, wt_total);
               p.alpha = FULL_ALPHA;
            end else begin
               p = '0;
            end
            blended_q.push_back(p);
            clear_sums();
         end
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task compare_field(string name, chan_type got, chan_type want);
         if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      task check_result(pixel_type got);
         pixel_type want;
         if (blended_q.size() == 0) begin
            report_mismatch($sformatf("pixel %h with nothing pending", got));
            return;
         end
         want = blended_q.pop_front();
         compare_field("out_blue", got.blue, want.blue);
         compare_field("out_green", got.green, want.green);
         compare_field("out_red", got.red, want.red);
         compare_field("out_alpha", got.alpha, want.alpha);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   wpb_req_if #(.WEIGHT_BITS(24), .COORD_BITS(16)) req_chan ();
   wpb_rsp_if rsp_chan ();
   wpb_csr_if csr_chan ();

   weighted_pixel_blender_unit #(
      .MAX_SOURCES (8),
      .WEIGHT_BITS (24),
      .COORD_BITS  (16)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   blend_scoreboard sb = new();

   int burst_left = 0;
   int cycle_count = 0;
   int rx_left = 0;
   int rx_style = RX_OPEN;
   bit rx_toggle = 1'b0;
   bit phase_modes [6] = '{MODE_MASK, MODE_ALPHA, MODE_MASK, MODE_ALPHA, MODE_ALPHA,
                           MODE_MASK};

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: check each transaction, then pick the next ready value
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         sb.check_result({rsp_chan.out_blue, rsp_chan.out_green, rsp_chan.out_red,
                          rsp_chan.out_alpha});
      if (rx_left <= 0) begin
         rx_style = $urandom_range(RX_OPEN, RX_TOGGLE);
         rx_left = (rx_style == RX_BLOCK) ? $urandom_range(3, 30) : $urandom_range(5, 60);
      end
      rx_left--;
      case (rx_style)
         RX_OPEN:  rsp_chan.ready <= 1'b1;
         RX_COIN:  rsp_chan.ready <= ($urandom_range(0, 99) < 60);
         RX_BLOCK: rsp_chan.ready <= 1'b0;
         default: begin
            rx_toggle = ~rx_toggle;
            rsp_chan.ready <= rx_toggle;
         end
      endcase
   end

   function automatic contrib_type mk(int b, int g, int r, int a, int w, int x, int y,
                                      int wd, int ht, bit last);
      contrib_type c;
      c.blue = 8'(b);
      c.green = 8'(g);
      c.red = 8'(r);
      c.alpha = 8'(a);
      c.weight = 24'(w);
      c.local_x = 16'(x);
      c.local_y = 16'(y);
      c.image_width = 15'(wd);
      c.image_height = 15'(ht);
      c.last_source = last;
      return c;
   endfunction

   function automatic logic signed [15:0] pick_coord(int extent, bit want_in);
      if (want_in && extent > 0)
         return 16'($urandom_range(0, extent - 1));
      case ($urandom_range(0, 4))
         0: return -16'sd1;
         1: return 16'(extent);
         2: return -16'sd32768;
         3: return 16'sd32767;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic contrib_type random_contrib(bit is_last, bit heavy);
      contrib_type c;
      int          wd;
      int          ht;
      bit          want_in;
      bit          x_out;
      c.blue = 8'($urandom_range(0, 255));
      c.green = 8'($urandom_range(0, 255));
      c.red = 8'($urandom_range(0, 255));
      c.alpha = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(125, 130)
                                               : $urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0:       c.weight = 24'd0;
         1:       c.weight = 24'hFFFFFF;
         2, 3:    c.weight = 24'($urandom_range(1, 255));
         4:       c.weight = 24'($urandom_range(24'hFF0000, 24'hFFFFFF));
         default: c.weight = 24'($urandom_range(0, 24'hFFFFFF));
      endcase
      case ($urandom_range(0, 9))
         0: begin
            wd = $urandom_range(0, 1) ? 0 : $urandom_range(1, 32767);
            ht = (wd == 0) ? $urandom_range(0, 32767) : 0;
         end
         1, 2, 3: begin
            wd = $urandom_range(1, 16);
            ht = $urandom_range(1, 16);
         end
         4: begin
            wd = 32767;
            ht = 32767;
         end
         default: begin
            wd = $urandom_range(1, 32767);
            ht = $urandom_range(1, 32767);
         end
      endcase
      if (heavy) begin
         c.weight = 24'($urandom_range(24'hF00000, 24'hFFFFFF));
         wd = $urandom_range(1, 32767);
         ht = $urandom_range(1, 32767);
      end
      want_in = heavy || ($urandom_range(0, 3) != 0);
      x_out = $urandom_range(0, 1);
      c.image_width = 15'(wd);
      c.image_height = 15'(ht);
      c.local_x = pick_coord(wd, want_in || !x_out);
      c.local_y = pick_coord(ht, want_in || x_out);
      c.last_source = is_last;
      return c;
   endfunction

   task automatic send_item(input contrib_type c);
      if (burst_left <= 0) begin
         req_chan.valid <= 1'b0;
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 4))
            @(posedge clock);
         burst_left = $urandom_range(1, 48);
      end
      req_chan.valid <= 1'b1;
      req_chan.blue <= c.blue;
      req_chan.green <= c.green;
      req_chan.red <= c.red;
      req_chan.alpha <= c.alpha;
      req_chan.weight <= c.weight;
      req_chan.local_x <= c.local_x;
      req_chan.local_y <= c.local_y;
      req_chan.image_width <= c.image_width;
      req_chan.image_height <= c.image_height;
      req_chan.last_source <= c.last_source;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      sb.note_input(c);
      burst_left--;
   endtask

   task automatic send_random_run(output int len);
      bit heavy;
      heavy = ($urandom_range(0, 19) == 0);
      len = heavy ? $urandom_range(9, 12) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
         send_item(random_contrib(i == len - 1, heavy));
   endtask

   task automatic finish_phase();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input bit mode);
      csr_chan.valid <= 1'b1;
      csr_chan.alpha_mode <= mode;
      @(posedge clock);
      while (csr_chan.ready !== 1'b1) @(posedge clock);
      sb.alpha_mode = mode;
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int sent;
      int run_len;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.blue <= '0;
      req_chan.green <= '0;
      req_chan.red <= '0;
      req_chan.alpha <= '0;
      req_chan.weight <= '0;
      req_chan.local_x <= '0;
      req_chan.local_y <= '0;
      req_chan.image_width <= '0;
      req_chan.image_height <= '0;
      req_chan.last_source <= 1'b0;
      csr_chan.valid <= 1'b0;
      csr_chan.alpha_mode <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // mask mode corners
      write_mode(MODE_MASK);
      send_item(mk(255, 255, 255, 255, 24'hFFFFFF, 0, 0, 1, 1, 1'b1));
      send_item(mk(0, 0, 0, 0, 0, 0, 0, 1, 1, 1'b1));
      send_item(mk(200, 100, 50, 0, 1000, -1, 0, 10, 10, 1'b1));
      send_item(mk(200, 100, 50, 0, 1000, 10, 3, 10, 10, 1'b1));
      send_item(mk(9, 9, 9, 9, 500, 32767, 32767, 32767, 32767, 1'b0));
      send_item(mk(40, 80, 160, 0, 7, 32766, 32766, 32767, 32767, 1'b1));
      send_item(mk(90, 90, 90, 90, 300, 0, 0, 0, 5, 1'b1));
      send_item(mk(90, 90, 90, 90, 300, 0, 0, 5, 0, 1'b1));
      send_item(mk(0, 0, 255, 0, 1, 0, 0, 4, 4, 1'b0));
      send_item(mk(1, 2, 0, 0, 1, 3, 3, 4, 4, 1'b1));
      send_item(mk(33, 66, 99, 0, 1234, 2, -32768, 8, 8, 1'b1));
      // totals saturate: the quotient clamps
      for (int i = 0; i < 9; i++)
         send_item(mk(255, 255, 255, 255, 24'hFFFFFF, 1, 1, 2, 2, i == 8));
      finish_phase();

      // alpha mode threshold
      write_mode(MODE_ALPHA);
      send_item(mk(77, 77, 77, 127, 0, 0, 0, 1, 1, 1'b1));
      send_item(mk(10, 0, 255, 128, 0, 0, 0, 2, 2, 1'b0));
      send_item(mk(11, 1, 254, 255, 24'hFFFFFF, 1, 1, 2, 2, 1'b0));
      send_item(mk(200, 200, 200, 0, 5, 0, 1, 2, 2, 1'b1));
      send_item(mk(50, 60, 70, 255, 5, 0, 2, 2, 2, 1'b1));
      finish_phase();

      foreach (phase_modes[p]) begin
         write_mode(phase_modes[p]);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            send_random_run(run_len);
            sent += run_len;
         end
         finish_phase();
      end

      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
